### sv/dmab_pkg.sv
package dmab_pkg;

  localparam int DMAB_MAX_CHANNELS = 8;
  localparam int DMAB_BANK_SLOTS   = 8;
  localparam int DMAB_DESC_BYTES   = 32;

  localparam int ADDR_W = 32;
  localparam int CFG_IW = 3;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IW-1:0] REG_BATCH_SIZE    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_POOL_BASE     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_POOL_STRIDE   = 3'd3;

  localparam logic [1:0] K_WRITE = 2'd0;
  localparam logic [1:0] K_CUT   = 2'd1;
  localparam logic [1:0] K_TRIG  = 2'd2;
  localparam logic [1:0] K_DONE  = 2'd3;

  typedef enum logic {
    OP_SUBMIT,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] len;
  } req_t;

  typedef struct packed {
    logic              we;
    logic [CFG_IW-1:0] index;
    logic [ADDR_W-1:0] data;
  } cfg_wr_t;

endpackage

### sv/dmab_front.sv
module dmab_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_command,
  input  logic [31:0]   in_dest_addr,
  input  logic [31:0]   in_src_addr,
  input  logic [31:0]   in_byte_count,
  output dmab_pkg::req_t q_req,
  output logic          q_valid,
  input  logic          q_pop
);
  import dmab_pkg::*;

  req_t           mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           push;
  req_t           req_in;

  assign in_stall = (cnt_r == QCW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = mem_r[rd_ptr_r];

  always_comb begin
    req_in.op   = in_command ? OP_FLUSH : OP_SUBMIT;
    req_in.dest = in_dest_addr;
    req_in.src  = in_src_addr;
    req_in.len  = in_byte_count;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + QCW'(1);
        2'b01:   cnt_r <= cnt_r - QCW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### sv/dmab_back.sv
module dmab_back #(
  parameter int MAX_CHANNELS = dmab_pkg::DMAB_MAX_CHANNELS,
  parameter int BANK_SLOTS   = dmab_pkg::DMAB_BANK_SLOTS,
  parameter int DESC_BYTES   = dmab_pkg::DMAB_DESC_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dmab_pkg::cfg_wr_t cfg,
  input  dmab_pkg::req_t    q_req,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [2:0]        out_channel,
  output logic [31:0]       out_slot_addr,
  output logic [31:0]       out_link_addr,
  output logic [31:0]       out_dest,
  output logic [31:0]       out_src,
  output logic [31:0]       out_length,
  output logic              out_last
);
  import dmab_pkg::*;

  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNW = $clog2(MAX_CHANNELS + 1);
  localparam int FW  = (BANK_SLOTS > 1) ? $clog2(BANK_SLOTS) : 1;
  localparam int BW  = $clog2(BANK_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_SCAN,
    S_FTRIG,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [3:0]        batch_r;
  logic [3:0]        chcnt_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] stride_r;

  logic [CW-1:0]     cur_r;
  logic [CNW-1:0]    work_ch_r;
  logic              bank_r [MAX_CHANNELS];
  logic [FW-1:0]     fill_r [MAX_CHANNELS];

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [1:0]        out_kind_r;
  logic [2:0]        out_chan_r;
  logic [ADDR_W-1:0] out_slot_r;
  logic [ADDR_W-1:0] out_link_r;
  logic [ADDR_W-1:0] out_dest_r;
  logic [ADDR_W-1:0] out_src_r;
  logic [ADDR_W-1:0] out_len_r;
  logic              out_last_r;

  logic [CNW-1:0]    eff_cnt;
  logic [BW-1:0]     eff_batch;
  logic [CW-1:0]     sub_ch;
  logic [CW-1:0]     ch_idx;
  logic [CNW-1:0]    next_ch;
  logic              cur_bank;
  logic [FW-1:0]     cur_fill;
  logic              trig;
  logic              can_emit;
  logic [ADDR_W-1:0] start_slot;
  logic [ADDR_W-1:0] slot_num;
  logic [ADDR_W-1:0] chan_off;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    if (chcnt_r == 4'd0) begin
      eff_cnt = CNW'(1);
    end else if (32'(chcnt_r) > 32'(MAX_CHANNELS)) begin
      eff_cnt = CNW'(MAX_CHANNELS);
    end else begin
      eff_cnt = CNW'(chcnt_r);
    end
    if (batch_r == 4'd0) begin
      eff_batch = BW'(1);
    end else if (32'(batch_r) > 32'(BANK_SLOTS)) begin
      eff_batch = BW'(BANK_SLOTS);
    end else begin
      eff_batch = BW'(batch_r);
    end
  end

  // a stale channel pointer past the served count falls back to channel 0
  assign sub_ch   = (CNW'(cur_r) >= eff_cnt) ? '0 : cur_r;
  assign ch_idx   = (state_r == S_IDLE) ? sub_ch : work_ch_r[CW-1:0];
  assign cur_bank = bank_r[ch_idx];
  assign cur_fill = fill_r[ch_idx];
  assign trig     = (BW'(cur_fill) + BW'(1)) >= eff_batch;
  assign next_ch  = ((CNW'(ch_idx) + CNW'(1)) >= eff_cnt) ? '0 : CNW'(ch_idx) + CNW'(1);
  assign can_emit = !out_valid_r || !out_stall;

  // one slot address per cycle: pool base + channel offset + slot offset
  always_comb begin
    start_slot = cur_bank ? ADDR_W'(BANK_SLOTS) : '0;
    case (state_r)
      S_IDLE:  slot_num = start_slot + ADDR_W'(cur_fill);
      S_SCAN:  slot_num = start_slot + ADDR_W'(cur_fill) - ADDR_W'(1);
      default: slot_num = start_slot;
    endcase
    chan_off = ADDR_W'(ADDR_W'(ch_idx) * stride_r);
    addr     = base_r + chan_off + ADDR_W'(slot_num * ADDR_W'(DESC_BYTES));
  end

  assign q_pop = (state_r == S_IDLE) && q_valid && ((q_req.op == OP_FLUSH) || can_emit);

  // output register holds while stalled, reloads whenever a result is issued
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (q_pop && (q_req.op == OP_SUBMIT)) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_SCAN: begin
        if ((work_ch_r < eff_cnt) && (cur_fill != '0) && can_emit) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_TRIG, S_FTRIG, S_DONE: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      batch_r     <= 4'd1;
      chcnt_r     <= 4'd2;
      base_r      <= '0;
      stride_r    <= ADDR_W'(512);
      cur_r       <= '0;
      work_ch_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        bank_r[i] <= 1'b0;
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          REG_BATCH_SIZE:    batch_r  <= cfg.data[3:0];
          REG_CHANNEL_COUNT: chcnt_r  <= cfg.data[3:0];
          REG_POOL_BASE:     base_r   <= cfg.data;
          REG_POOL_STRIDE:   stride_r <= cfg.data;
          default: ;
        endcase
      end

      out_valid_r <= out_valid_nxt;

      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_req.op == OP_SUBMIT) begin
              out_kind_r  <= K_WRITE;
              out_chan_r  <= 3'(ch_idx);
              out_slot_r  <= addr;
              out_link_r  <= trig ? '0 : addr + ADDR_W'(DESC_BYTES);
              out_dest_r  <= q_req.dest;
              out_src_r   <= q_req.src;
              out_len_r   <= q_req.len;
              out_last_r  <= !trig;
              work_ch_r   <= CNW'(ch_idx);
              if (trig) begin
                state_r <= S_TRIG;
              end else begin
                fill_r[ch_idx] <= cur_fill + FW'(1);
                cur_r          <= ch_idx;
              end
            end else begin
              work_ch_r <= '0;
              state_r   <= S_SCAN;
            end
          end
        end
        S_TRIG: begin
          if (can_emit) begin
            out_kind_r     <= K_TRIG;
            out_chan_r     <= 3'(ch_idx);
            out_slot_r     <= addr;
            out_link_r     <= '0;
            out_dest_r     <= '0;
            out_src_r      <= '0;
            out_len_r      <= '0;
            out_last_r     <= 1'b1;
            bank_r[ch_idx] <= !cur_bank;
            fill_r[ch_idx] <= '0;
            cur_r          <= next_ch[CW-1:0];
            state_r        <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (work_ch_r >= eff_cnt) begin
            state_r <= S_DONE;
          end else if (cur_fill == '0) begin
            work_ch_r <= work_ch_r + CNW'(1);
          end else if (can_emit) begin
            out_kind_r  <= K_CUT;
            out_chan_r  <= 3'(ch_idx);
            out_slot_r  <= addr;
            out_link_r  <= '0;
            out_dest_r  <= '0;
            out_src_r   <= '0;
            out_len_r   <= '0;
            out_last_r  <= 1'b0;
            state_r     <= S_FTRIG;
          end
        end
        S_FTRIG: begin
          if (can_emit) begin
            out_kind_r     <= K_TRIG;
            out_chan_r     <= 3'(ch_idx);
            out_slot_r     <= addr;
            out_link_r     <= '0;
            out_dest_r     <= '0;
            out_src_r      <= '0;
            out_len_r      <= '0;
            out_last_r     <= 1'b0;
            bank_r[ch_idx] <= !cur_bank;
            fill_r[ch_idx] <= '0;
            work_ch_r      <= work_ch_r + CNW'(1);
            state_r        <= S_SCAN;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            out_kind_r  <= K_DONE;
            out_chan_r  <= '0;
            out_slot_r  <= '0;
            out_link_r  <= '0;
            out_dest_r  <= '0;
            out_src_r   <= '0;
            out_len_r   <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_channel   = out_chan_r;
  assign out_slot_addr = out_slot_r;
  assign out_link_addr = out_link_r;
  assign out_dest      = out_dest_r;
  assign out_src       = out_src_r;
  assign out_length    = out_len_r;
  assign out_last      = out_last_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE))
    else $error("request popped while sequencer busy");

  a_ftrig_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FTRIG && can_emit) |=> (out_valid_r && out_kind_r == K_TRIG && !out_last_r))
    else $error("flush trigger not emitted as a non-final result");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && can_emit) |=>
      (out_valid_r && out_kind_r == K_DONE && out_last_r && out_slot_r == '0))
    else $error("flush done marker malformed");

  a_cut_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == K_CUT) |-> (!out_last_r && state_r == S_FTRIG))
    else $error("chain cut not followed by its trigger");

endmodule

### sv/dma_descriptor_batcher_top.sv
// DMA descriptor batcher. Copy requests and flush commands enter a two-entry
// request queue; a sequencer behind it keeps per-channel ping-pong bank and fill
// state and drives at most one result per cycle, while the output is not
// stalled, into an output register. A submit issues a descriptor write, and
// then a channel trigger when it completes a batch. A flush issues, for each
// served channel holding a partial batch, a cut and then a trigger, skips
// empty channels and ends with a done marker. The sequencer takes no new
// request until idle again; each result needs an unstalled output slot.
// Descriptor addresses are pool_base + channel * pool_stride + slot * DESC_BYTES,
// modulo 2^32. Configuration is to be written through cfg_we/cfg_index/cfg_data
// while no request is in flight; the block does not enforce it. Unknown indexes
// are ignored. No clearing pass: all state is ready in the cycle after reset.
module dma_descriptor_batcher_top #(
  parameter int MAX_CHANNELS = dmab_pkg::DMAB_MAX_CHANNELS,
  parameter int BANK_SLOTS   = dmab_pkg::DMAB_BANK_SLOTS,
  parameter int DESC_BYTES   = dmab_pkg::DMAB_DESC_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [31:0]                 in_dest_addr,
  input  logic [31:0]                 in_src_addr,
  input  logic [31:0]                 in_byte_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [2:0]                  out_channel,
  output logic [31:0]                 out_slot_addr,
  output logic [31:0]                 out_link_addr,
  output logic [31:0]                 out_dest,
  output logic [31:0]                 out_src,
  output logic [31:0]                 out_length,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [dmab_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import dmab_pkg::*;

  req_t    q_req;
  logic    q_valid;
  logic    q_pop;
  cfg_wr_t cfg;

  always_comb begin
    cfg.we    = cfg_we;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  dmab_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_dest_addr  (in_dest_addr),
    .in_src_addr   (in_src_addr),
    .in_byte_count (in_byte_count),
    .q_req         (q_req),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  dmab_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .BANK_SLOTS   (BANK_SLOTS),
    .DESC_BYTES   (DESC_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_req         (q_req),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_channel   (out_channel),
    .out_slot_addr (out_slot_addr),
    .out_link_addr (out_link_addr),
    .out_dest      (out_dest),
    .out_src       (out_src),
    .out_length    (out_length),
    .out_last      (out_last)
  );

endmodule

### tb/dma_descriptor_batcher_top_test.sv
`timescale 1ns / 100ps

module dma_descriptor_batcher_top_test;
  import dmab_pkg::*;

  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  channel;
    logic [31:0] slot_addr;
    logic [31:0] link_addr;
    logic [31:0] dest;
    logic [31:0] src;
    logic [31:0] length;
    logic        last;
  } result_t;

  // Tracks pool registers, round-robin pointer and per-channel bank/fill state,
  // and queues the descriptor traffic each request must produce.
  class descriptor_predictor;
    logic [3:0]  batch_reg;
    logic [3:0]  count_reg;
    logic [31:0] base_reg;
    logic [31:0] stride_reg;
    int          cur_ch;
    bit          bank_sel[DMAB_MAX_CHANNELS];
    int          fill_cnt[DMAB_MAX_CHANNELS];
    result_t     pending_results[$];
    int          fail_count;

    function new();
      batch_reg  = 4'd1;
      count_reg  = 4'd2;
      base_reg   = '0;
      stride_reg = 32'd512;
      cur_ch     = 0;
      fail_count = 0;
      foreach (bank_sel[i]) begin
        bank_sel[i] = 1'b0;
        fill_cnt[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
      case (idx)
        REG_BATCH_SIZE:    batch_reg  = data[3:0];
        REG_CHANNEL_COUNT: count_reg  = data[3:0];
        REG_POOL_BASE:     base_reg   = data;
        REG_POOL_STRIDE:   stride_reg = data;
        default: ;
      endcase
    endfunction

    function int eff_batch();
      if (batch_reg == 0) return 1;
      if (batch_reg > DMAB_BANK_SLOTS) return DMAB_BANK_SLOTS;
      return int'(batch_reg);
    endfunction

    function int eff_count();
      if (count_reg == 0) return 1;
      if (count_reg > DMAB_MAX_CHANNELS) return DMAB_MAX_CHANNELS;
      return int'(count_reg);
    endfunction

    // address arithmetic wraps at 32 bits
    function logic [31:0] slot_at(int ch, int slot);
      logic [31:0] ch32;
      logic [31:0] off32;
      ch32  = ch;
      off32 = slot * DMAB_DESC_BYTES;
      return base_reg + ch32 * stride_reg + off32;
    endfunction

    function void add(logic [1:0] kind, int ch, logic [31:0] slot, logic [31:0] link,
                      logic [31:0] d, logic [31:0] s, logic [31:0] l);
      result_t r;
      r.kind      = kind;
      r.channel   = ch[2:0];
      r.slot_addr = slot;
      r.link_addr = link;
      r.dest      = d;
      r.src       = s;
      r.length    = l;
      r.last      = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void note_request(op_t op, logic [31:0] d, logic [31:0] s, logic [31:0] l);
      int      cnt;
      int      ch;
      int      idx;
      int      start;
      bit      trig;
      result_t tail;
      cnt = eff_count();
      if (op == OP_SUBMIT) begin
        ch = (cur_ch >= cnt) ? 0 : cur_ch;
        start = bank_sel[ch] ? DMAB_BANK_SLOTS : 0;
        idx = fill_cnt[ch];
        // fill may already sit past a lowered batch size
        trig = (idx + 1) >= eff_batch();
        add(K_WRITE, ch, slot_at(ch, start + idx),
            trig ? 32'd0 : slot_at(ch, start + idx + 1), d, s, l);
        if (trig) begin
          fill_cnt[ch] = 0;
          bank_sel[ch] = !bank_sel[ch];
          add(K_TRIG, ch, slot_at(ch, start), '0, '0, '0, '0);
          cur_ch = (ch + 1 >= cnt) ? 0 : ch + 1;
        end else begin
          fill_cnt[ch] = idx + 1;
          cur_ch = ch;
        end
      end else begin
        for (ch = 0; ch < cnt; ch++) begin
          if (fill_cnt[ch] != 0) begin
            start = bank_sel[ch] ? DMAB_BANK_SLOTS : 0;
            add(K_CUT, ch, slot_at(ch, start + fill_cnt[ch] - 1), '0, '0, '0, '0);
            add(K_TRIG, ch, slot_at(ch, start), '0, '0, '0, '0);
            bank_sel[ch] = !bank_sel[ch];
            fill_cnt[ch] = 0;
          end
        end
        add(K_DONE, 0, '0, '0, '0, '0, '0);
      end
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: kind %0d channel %0d slot 0x%0h",
               got.kind, got.channel, got.slot_addr);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("channel", want.channel, got.channel);
      compare_field("slot_addr", want.slot_addr, got.slot_addr);
      compare_field("link_addr", want.link_addr, got.link_addr);
      compare_field("out_dest", want.dest, got.dest);
      compare_field("out_src", want.src, got.src);
      compare_field("out_length", want.length, got.length);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_command = 1'b0;
  logic [31:0]       in_dest_addr = '0;
  logic [31:0]       in_src_addr = '0;
  logic [31:0]       in_byte_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  logic [2:0]        out_channel;
  logic [31:0]       out_slot_addr;
  logic [31:0]       out_link_addr;
  logic [31:0]       out_dest;
  logic [31:0]       out_src;
  logic [31:0]       out_length;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  descriptor_predictor pred;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  dma_descriptor_batcher_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_dest_addr (in_dest_addr),
    .in_src_addr  (in_src_addr),
    .in_byte_count(in_byte_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_channel  (out_channel),
    .out_slot_addr(out_slot_addr),
    .out_link_addr(out_link_addr),
    .out_dest     (out_dest),
    .out_src      (out_src),
    .out_length   (out_length),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dma_descriptor_batcher_top_test: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // request first: a result never leaves in the cycle its request enters
  always @(posedge clk) begin : watch_ports
    result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        pred.note_request(op_t'(in_command), in_dest_addr, in_src_addr, in_byte_count);
      if (out_valid && !out_stall) begin
        got.kind      = out_kind;
        got.channel   = out_channel;
        got.slot_addr = out_slot_addr;
        got.link_addr = out_link_addr;
        got.dest      = out_dest;
        got.src       = out_src;
        got.length    = out_length;
        got.last      = out_last;
        pred.check_result(got);
      end
    end
  end

  function automatic int idle_gap(int pct);
    int g;
    g = 0;
    while (($urandom_range(99) < pct) && (g < 60)) g++;
    return g;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic push_request(op_t op, logic [31:0] d, logic [31:0] s, logic [31:0] l);
    int gap;
    gap = idle_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_command    = op;
    in_dest_addr  = d;
    in_src_addr   = s;
    in_byte_count = l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pred.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    pred.write_reg(idx, data);
  endtask

  task automatic set_pool(logic [31:0] batch, logic [31:0] count, logic [31:0] base,
                          logic [31:0] stride);
    write_reg(REG_BATCH_SIZE, batch);
    write_reg(REG_CHANNEL_COUNT, count);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_POOL_STRIDE, stride);
  endtask

  task automatic submit_rand();
    push_request(OP_SUBMIT, rand_word(), rand_word(), rand_word());
  endtask

  task automatic flush_all();
    push_request(OP_FLUSH, $urandom, $urandom, $urandom);
  endtask

  task automatic set_idling(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 75; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 75; end
      default: begin send_idle_pct = 8; stall_pct = 8; end
    endcase
  endtask

  task automatic run_segment(int seg);
    logic [31:0] batch;
    logic [31:0] count;
    logic [31:0] stride;
    op_t         op;
    if (seg == 0) begin
      set_pool(32'd8, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end else if (seg == 1) begin
      set_pool(32'd0, 32'd0, 32'h0, 32'h0);
    end else begin
      batch  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 8);
      count  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 8);
      stride = ($urandom_range(1) == 0) ? rand_word() : $urandom_range(0, 64) * 32;
      set_pool(batch, count, rand_word(), stride);
    end
    write_reg(CFG_IW'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    set_idling(seg % 4);
    for (int i = 0; i < SEGMENT_ITEMS; i++) begin
      op = ($urandom_range(99) < 15) ? OP_FLUSH : OP_SUBMIT;
      push_request(op, rand_word(), rand_word(), rand_word());
      // hold the sender until the block has emptied
      if (i == SEGMENT_ITEMS / 2 || $urandom_range(29) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    pred = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: batch of one, two channels
    push_request(OP_SUBMIT, 32'h0, 32'h0, 32'h0);
    push_request(OP_SUBMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    flush_all();  // nothing partial, done marker only
    wait_drained();

    set_pool(32'd3, 32'd4, 32'h8000_0000, 32'h100);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    submit_rand();
    submit_rand();
    flush_all();
    repeat (3) submit_rand();
    submit_rand();  // partial on channel 1
    wait_drained();

    // lowered batch: channel 1 already holds a full batch
    write_reg(REG_BATCH_SIZE, 32'd1);
    submit_rand();
    submit_rand();
    wait_drained();
    write_reg(REG_BATCH_SIZE, 32'd8);
    submit_rand();  // partial on channel 3
    wait_drained();

    // pointer beyond the count falls back to 0; channel 3 now unserved
    write_reg(REG_CHANNEL_COUNT, 32'd2);
    submit_rand();
    flush_all();
    wait_drained();

    set_pool(32'd0, 32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    flush_all();  // picks up channel 3 again
    push_request(OP_SUBMIT, 32'h0, 32'hFFFF_FFFF, 32'h0);
    push_request(OP_SUBMIT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_request(OP_SUBMIT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
    push_request(OP_SUBMIT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
    wait_drained();

    set_pool(32'd15, 32'd0, 32'h0, 32'h0);
    write_reg(REG_SPARE_HI, 32'h0);
    submit_rand();
    submit_rand();
    flush_all();
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) run_segment(seg);

    in_valid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (pred.fail_count == 0 && pred.pending_results.size() == 0) begin
      $display("dma_descriptor_batcher_top_test: done, clean");
    end else begin
      $display("dma_descriptor_batcher_top_test: done, errors");
    end
    $finish;
  end

endmodule
